// ===== rtl/core/mbet_pkg.sv =====
// Shared types, register indexes and a saturation helper for the escape-time pixel core.
package mbet_pkg;

    // Width that holds every intermediate sum before saturation
    localparam int WIDE_W = 68;

    typedef logic signed [WIDE_W-1:0] t_wide;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_LEFT     = 3'd0,
        CFG_Y_LOW      = 3'd1,
        CFG_STEP_X     = 3'd2,
        CFG_STEP_Y     = 3'd3,
        CFG_ITER_LIMIT = 3'd4,
        CFG_SPARE_5    = 3'd5,
        CFG_SPARE_6    = 3'd6,
        CFG_SPARE_7    = 3'd7
    } t_cfg_reg;

    // One point c, both parts in signed fixed point
    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } t_point;

    // Clamp a wide signed value into the 32-bit signed range
    function automatic logic signed [31:0] f_sat32(input t_wide v);
        logic fits;
        fits = (v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1);
        if (fits) begin
            return v[31:0];
        end else if (v[WIDE_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// ===== rtl/core/mbet_front.sv =====
// Front end: take pixel words, clamp the indices and form the point c.
module mbet_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [11:0]         i_column,
    input  logic [11:0]         i_row,
    input  logic signed [31:0]  i_x_left,
    input  logic signed [31:0]  i_y_low,
    input  logic signed [31:0]  i_step_x,
    input  logic signed [31:0]  i_step_y,
    input  logic                i_full,
    output logic                o_busy,
    output logic                o_push,
    output mbet_pkg::t_point    o_point
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;

    logic [15:0]        r_col, r_row, n_col, n_row;
    logic signed [48:0] r_px, r_py;
    logic               accept;

    assign accept = (r_state == F_IDLE) && i_start;

    // Clamp indices to the image size
    always_comb begin
        n_col = {4'b0, i_column};
        n_row = {4'b0, i_row};
        if ({5'b0, i_column} >= 17'(MAX_WIDTH)) begin
            n_col = 16'(MAX_WIDTH - 1);
        end
        if ({5'b0, i_row} >= 17'(MAX_HEIGHT)) begin
            n_row = 16'(MAX_HEIGHT - 1);
        end
    end

    // Sequence the word through multiply and add
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_start) n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold indices, then register the offset products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
        if (r_state == F_MUL) begin
            r_px <= $signed({1'b0, r_col}) * i_step_x;
            r_py <= $signed({1'b0, r_row}) * i_step_y;
        end
    end

    // Add the origin and saturate
    assign o_point.cr = mbet_pkg::f_sat32(mbet_pkg::t_wide'(r_px) +
                                          mbet_pkg::t_wide'(i_x_left));
    assign o_point.ci = mbet_pkg::f_sat32(mbet_pkg::t_wide'(r_py) +
                                          mbet_pkg::t_wide'(i_y_low));
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_busy     = (r_state != F_IDLE);

endmodule

// ===== rtl/core/mbet_queue.sv =====
// Two-word queue of points between front end and iteration engine.
module mbet_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mbet_pkg::t_point i_point,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output mbet_pkg::t_point o_point
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    mbet_pkg::t_point r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_point = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_point;
        end
    end

endmodule

// ===== rtl/core/mbet_back.sv =====
// Iteration engine: run z = z^2 + c and count passes until escape or limit.
module mbet_back #(
    parameter int FRAC_BITS = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  mbet_pkg::t_point i_point,
    input  logic [15:0]      i_max_iterations,
    output logic             o_pop,
    output logic             o_valid,
    output logic [16:0]      o_iteration_count,
    output logic             o_in_set
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_STEP = 3'b100
    } t_back_state;

    localparam logic [63:0] BOUND = 64'd4 << FRAC_BITS;

    t_back_state r_state, n_state;

    logic signed [31:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [16:0]        r_count, r_count_out;
    logic               r_first, r_valid, r_in_set;

    mbet_pkg::t_wide    diff, diff_sh;
    logic signed [63:0] ri_sh;
    logic signed [31:0] n_zr, n_zi;
    logic [63:0]        mag_sum;
    logic               escape, at_limit, done;

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    // Form the next z from the registered products
    always_comb begin
        diff    = mbet_pkg::t_wide'(r_rr) - mbet_pkg::t_wide'(r_ii);
        diff_sh = diff >>> FRAC_BITS;
        ri_sh   = r_ri >>> (FRAC_BITS - 1);
        n_zr    = mbet_pkg::f_sat32(diff_sh + mbet_pkg::t_wide'(r_cr));
        n_zi    = mbet_pkg::f_sat32(mbet_pkg::t_wide'(ri_sh) + mbet_pkg::t_wide'(r_ci));
    end

    // Test the current z, which the products were formed from
    assign mag_sum  = $unsigned(r_rr) + $unsigned(r_ii);
    assign escape   = !r_first && ((mag_sum >> FRAC_BITS) >= BOUND);
    assign at_limit = !r_first && (r_count >= {1'b0, i_max_iterations});
    assign done     = (r_state == B_STEP) && (escape || at_limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = B_MUL;
            B_MUL:  n_state = B_STEP;
            B_STEP: n_state = done ? B_IDLE : B_MUL;
            default: n_state = B_IDLE;
        endcase
    end

    // Control state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= done;
        end
    end

    // Datapath: load c, multiply, step z and count
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cr    <= i_point.cr;
            r_ci    <= i_point.ci;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
            r_first <= 1'b1;
        end
        if (r_state == B_MUL) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
        if (r_state == B_STEP) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_first <= 1'b0;
            if (!r_first && !escape) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (done) begin
            r_count_out <= escape ? r_count : r_count + 1'b1;
            r_in_set    <= !escape;
        end
    end

    assign o_valid           = r_valid;
    assign o_iteration_count = r_count_out;
    assign o_in_set          = r_in_set;

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel_core.sv =====
// Top level: configuration registers, front end, point queue and iteration engine.
// Flow: the front end takes a new word only once the last one is pushed into the queue;
// the engine pops a point only when idle and iterates it, alternating multiply and step
// states, before taking the next; the queue lets the front end run ahead while it has room.
// Reset: synchronous, active low; clears control state and loads the register defaults.
// Results appear on a one-cycle o_valid strobe; the receiver cannot stall.
module mandelbrot_escape_time_pixel_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int FRAC_BITS  = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [16:0] o_iteration_count,
    output logic        o_in_set
);

    logic signed [31:0] r_x_left, r_y_low, r_step_x, r_step_y;
    logic [15:0]        r_iter_limit;

    logic             push, pop, full, empty;
    mbet_pkg::t_point push_point, pop_point;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_left     <= -32'sd536870912;
            r_y_low      <= -32'sd402653184;
            r_step_x     <= 32'sd786432;
            r_step_y     <= 32'sd786432;
            r_iter_limit <= 16'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbet_pkg::CFG_X_LEFT:     r_x_left     <= i_cfg_data;
                mbet_pkg::CFG_Y_LOW:      r_y_low      <= i_cfg_data;
                mbet_pkg::CFG_STEP_X:     r_step_x     <= i_cfg_data;
                mbet_pkg::CFG_STEP_Y:     r_step_y     <= i_cfg_data;
                mbet_pkg::CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    mbet_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_column (i_column),
        .i_row    (i_row),
        .i_x_left (r_x_left),
        .i_y_low  (r_y_low),
        .i_step_x (r_step_x),
        .i_step_y (r_step_y),
        .i_full   (full),
        .o_busy   (busy),
        .o_push   (push),
        .o_point  (push_point)
    );

    mbet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_point),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_point (pop_point)
    );

    mbet_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_point           (pop_point),
        .i_max_iterations  (r_iter_limit),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .o_iteration_count (o_iteration_count),
        .o_in_set          (o_in_set)
    );

endmodule

// ===== sim/mandelbrot_escape_time_pixel_core_tb.sv =====
// Self-checking testbench for the escape-time pixel core: directed corners, then random phases.
module mandelbrot_escape_time_pixel_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int STALL_LIMIT = 400_000;
    localparam logic [31:0] Q_ONE = 32'h1000_0000;

    typedef struct {
        logic [16:0] count;
        logic        in_set;
    } t_escape_result;

    // Track register contents, predict escape counts and match them in order
    class pixel_count_board;
        int          x_left;
        int          y_low;
        int          step_x;
        int          step_y;
        int unsigned iter_limit;
        t_escape_result expected_q[$];
        int          fail_count;

        function new();
            x_left     = -536870912;
            y_low      = -402653184;
            step_x     = 786432;
            step_y     = 786432;
            iter_limit = 255;
            fail_count = 0;
        endfunction

        function void set_reg(mbet_pkg::t_cfg_reg idx, logic [31:0] data);
            case (idx)
                mbet_pkg::CFG_X_LEFT:     x_left     = $signed(data);
                mbet_pkg::CFG_Y_LOW:      y_low      = $signed(data);
                mbet_pkg::CFG_STEP_X:     step_x     = $signed(data);
                mbet_pkg::CFG_STEP_Y:     step_y     = $signed(data);
                mbet_pkg::CFG_ITER_LIMIT: iter_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function int clip32(longint v);
            if (v > longint'(32'sh7FFF_FFFF)) begin
                return 32'sh7FFF_FFFF;
            end else if (v < -longint'(64'sh8000_0000)) begin
                return 32'sh8000_0000;
            end
            return int'(v);
        endfunction

        // Iterate z = z*z + c until escape or the limit, count as the engine does
        function t_escape_result predict_escape(int unsigned col, int unsigned row);
            t_escape_result res;
            int unsigned    c_idx;
            int unsigned    r_idx;
            int             cr;
            int             ci;
            int             zr;
            int             zi;
            int             nr;
            int             ni;
            longint         rr;
            longint         ii;
            longint         ri;
            logic [63:0]    mag;
            int unsigned    count;
            bit             stop;
            c_idx = (col >= MAX_WIDTH)  ? MAX_WIDTH - 1  : col;
            r_idx = (row >= MAX_HEIGHT) ? MAX_HEIGHT - 1 : row;
            cr = clip32(longint'(x_left) + longint'(c_idx) * longint'(step_x));
            ci = clip32(longint'(y_low) + longint'(r_idx) * longint'(step_y));
            zr = 0;
            zi = 0;
            count = 0;
            while (1) begin
                rr = longint'(zr) * longint'(zr);
                ii = longint'(zi) * longint'(zi);
                ri = longint'(zr) * longint'(zi);
                nr = clip32(((rr - ii) >>> FRAC_BITS) + longint'(cr));
                ni = clip32((ri >>> (FRAC_BITS - 1)) + longint'(ci));
                zr = nr;
                zi = ni;
                rr = longint'(zr) * longint'(zr);
                ii = longint'(zi) * longint'(zi);
                mag = (unsigned'(rr) + unsigned'(ii)) >> FRAC_BITS;
                if (mag >= (64'd4 << FRAC_BITS)) begin
                    break;
                end
                stop = (count >= iter_limit);
                count++;
                if (stop) begin
                    break;
                end
            end
            res.count  = count[16:0];
            res.in_set = (count > iter_limit);
            return res;
        endfunction

        function void note_pixel(int unsigned col, int unsigned row);
            expected_q.push_back(predict_escape(col, row));
        endfunction

        function void check_result(logic [16:0] count, logic in_set);
            t_escape_result exp_res;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: iteration_count=%0d in_set=%0d",
                       count, in_set);
                fail_count++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (count !== exp_res.count) begin
                $error("iteration_count: expected %0d, got %0d", exp_res.count, count);
                fail_count++;
            end
            if (in_set !== exp_res.in_set) begin
                $error("in_set: expected %0d, got %0d", exp_res.in_set, in_set);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] i_column = '0;
    logic [11:0] i_row = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [16:0] o_iteration_count;
    logic        o_in_set;

    pixel_count_board sb = new();
    int idle_cycles = 0;

    mandelbrot_escape_time_pixel_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_iteration_count (o_iteration_count),
        .o_in_set          (o_in_set)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_iteration_count, o_in_set);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write one register, then drop the enable before returning
    task automatic cfg_write(input mbet_pkg::t_cfg_reg idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one pixel word; start stays high when the next word follows at once
    task automatic send_pixel(input int unsigned col, input int unsigned row, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_column <= col[11:0];
        i_row    <= row[11:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_pixel(col[11:0], row[11:0]);
    endtask

    // Hold off until every expected word has arrived and the engine settles
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return Q_ONE;
        endcase
    endfunction

    initial begin
        int          sent;
        int          n_items;
        int          mode;
        int          gap;
        bit          quiet;
        int unsigned step_x_val;
        int unsigned step_y_val;
        int unsigned col_top;
        int unsigned row_top;
        logic [31:0] data;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window: corners, a point inside, the point -2 on the boundary
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(512, 512, 0);
        send_pixel(0, 512, 3);
        send_pixel(4095, 0, 0);
        send_pixel(0, 4095, 1);
        send_pixel(700, 512, 0);
        send_pixel(400, 700, 5);
        send_pixel(682, 512, 0);
        drain();

        // Zero limit: one pass only
        cfg_write(mbet_pkg::CFG_ITER_LIMIT, 32'd0);
        send_pixel(512, 512, 0);
        send_pixel(4095, 4095, 0);
        drain();

        // Writes to unused indexes must leave the registers alone
        cfg_write(mbet_pkg::CFG_SPARE_5, 32'hFFFF_FFFF);
        cfg_write(mbet_pkg::CFG_SPARE_6, 32'h0000_0000);
        cfg_write(mbet_pkg::CFG_SPARE_7, 32'hA5A5_A5A5);
        send_pixel(512, 512, 0);
        drain();

        // Saturating start points in both directions
        cfg_write(mbet_pkg::CFG_X_LEFT, 32'h7FFF_FFFF);
        cfg_write(mbet_pkg::CFG_STEP_X, 32'h7FFF_FFFF);
        cfg_write(mbet_pkg::CFG_Y_LOW, 32'h8000_0000);
        cfg_write(mbet_pkg::CFG_STEP_Y, 32'h8000_0000);
        cfg_write(mbet_pkg::CFG_ITER_LIMIT, 32'd7);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 0, 0);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 2);
        drain();

        // Full limit at the origin: never escapes
        cfg_write(mbet_pkg::CFG_X_LEFT, 32'd0);
        cfg_write(mbet_pkg::CFG_Y_LOW, 32'd0);
        cfg_write(mbet_pkg::CFG_STEP_X, 32'd0);
        cfg_write(mbet_pkg::CFG_STEP_Y, 32'd0);
        cfg_write(mbet_pkg::CFG_ITER_LIMIT, 32'h0000_FFFF);
        send_pixel(3, 3, 0);
        drain();

        // Random phases, each with its own register setting
        sent = 0;
        while (sent < 1100) begin
            mode = $urandom_range(0, 19);
            if (mode < 12) begin
                // Window over the set: counts spread over the whole range
                step_x_val = $urandom_range(1 << 12, 1 << 21);
                step_y_val = $urandom_range(1 << 12, 1 << 21);
                cfg_write(mbet_pkg::CFG_X_LEFT, $urandom_range(0, 3 << 28) - (5 << 27));
                cfg_write(mbet_pkg::CFG_Y_LOW, $urandom_range(0, 2 << 28) - (3 << 27));
                cfg_write(mbet_pkg::CFG_STEP_X, step_x_val);
                cfg_write(mbet_pkg::CFG_STEP_Y, step_y_val);
                if ($urandom_range(0, 4) == 0) begin
                    cfg_write(mbet_pkg::CFG_ITER_LIMIT, $urandom_range(61, 300));
                end else begin
                    cfg_write(mbet_pkg::CFG_ITER_LIMIT, $urandom_range(1, 60));
                end
                col_top = ((3 << 28) / step_x_val > 4095) ? 4095 : (3 << 28) / step_x_val;
                row_top = ((2 << 28) / step_y_val > 4095) ? 4095 : (2 << 28) / step_y_val;
            end else if (mode < 17) begin
                cfg_write(mbet_pkg::CFG_X_LEFT, $urandom);
                cfg_write(mbet_pkg::CFG_Y_LOW, $urandom);
                cfg_write(mbet_pkg::CFG_STEP_X, $urandom);
                cfg_write(mbet_pkg::CFG_STEP_Y, $urandom);
                cfg_write(mbet_pkg::CFG_ITER_LIMIT,
                          {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'd0}
                          | $urandom_range(0, 40));
                col_top = 4095;
                row_top = 4095;
            end else begin
                cfg_write(mbet_pkg::CFG_X_LEFT, edge_value());
                cfg_write(mbet_pkg::CFG_Y_LOW, edge_value());
                cfg_write(mbet_pkg::CFG_STEP_X, edge_value());
                cfg_write(mbet_pkg::CFG_STEP_Y, edge_value());
                cfg_write(mbet_pkg::CFG_ITER_LIMIT, $urandom_range(0, 20));
                col_top = 4095;
                row_top = 4095;
            end
            if ($urandom_range(0, 3) == 0) begin
                data = $urandom;
                cfg_write(mbet_pkg::t_cfg_reg'($urandom_range(mbet_pkg::CFG_SPARE_5,
                                                              mbet_pkg::CFG_SPARE_7)),
                          data);
            end

            n_items = $urandom_range(30, 90);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (n_items) begin
                gap = quiet ? 0 : $urandom_range(0, 17);
                send_pixel($urandom_range(0, col_top), $urandom_range(0, row_top), gap);
                sent++;
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending() > 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
